>>> rtl/jqsd_pkg.sv
// Package with the constants, codes and types of the job queue server dispatcher.
`timescale 1ns / 1ps

package jqsd_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_SERVERS = 8;
    localparam int JOB_ID_BITS = 16;

    localparam int ACTION_W = 2;
    localparam int JOB_W    = 16;
    localparam int SIDX_W   = 3;
    localparam int COUNT_W  = 7;
    localparam int ERR_W    = 2;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] CFG_SERVERS_RESET = 4'd8;

    localparam logic [ACTION_W-1:0] ACT_ARRIVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PULL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIRE   = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_INDEX = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FIRE_IDLE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [JOB_W-1:0]    job_id;
        logic [SIDX_W-1:0]   server_index;
    } t_in_item;

    typedef struct packed {
        logic                dispatched;
        logic [JOB_W-1:0]    dispatched_job;
        logic [SIDX_W-1:0]   dispatch_server;
        logic                sending;
        logic [COUNT_W-1:0]  queue_count;
        logic [ERR_W-1:0]    error_code;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

>>> rtl/jqsd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module jqsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/jqsd_ctrl.sv
// Controller state machine that sequences input transfers, execution and the result register.
`timescale 1ns / 1ps

module jqsd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jqsd_pkg::t_ctl_cmd o_cmd
);

    jqsd_pkg::t_state r_state;
    jqsd_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jqsd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        case (r_state)
            jqsd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = jqsd_pkg::ST_EXEC;
                end
            end
            jqsd_pkg::ST_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = jqsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jqsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/jqsd_datapath.sv
// Datapath with the job queue, server ready bits, dispatch match and result register.
`timescale 1ns / 1ps

module jqsd_datapath #(
    parameter int QUEUE_DEPTH = jqsd_pkg::QUEUE_DEPTH,
    parameter int MAX_SERVERS = jqsd_pkg::MAX_SERVERS,
    parameter int JOB_ID_BITS = jqsd_pkg::JOB_ID_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jqsd_pkg::t_ctl_cmd              i_cmd,
    input  jqsd_pkg::t_in_item              i_in_data,
    input  logic                            i_cfg_wr_en,
    input  logic [jqsd_pkg::CFG_W-1:0]      i_cfg_wr_data,
    output jqsd_pkg::t_out_item             o_out_data
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = (JOB_ID_BITS < jqsd_pkg::JOB_W) ? JOB_ID_BITS : jqsd_pkg::JOB_W;
    localparam int SIW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int NW    = 7;
    localparam int JW    = jqsd_pkg::JOB_W;
    localparam int XW    = jqsd_pkg::SIDX_W;
    localparam int CW    = jqsd_pkg::COUNT_W;
    localparam logic [NW-1:0]          MAX_S = NW'(MAX_SERVERS);
    localparam logic [AW-1:0]          LAST  = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0]          FULL  = FW'(QUEUE_DEPTH);
    localparam logic [MAX_SERVERS-1:0] ONE_S = MAX_SERVERS'(1);

    jqsd_pkg::t_in_item         r_item;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              r_tail;
    logic [FW-1:0]              r_fill;
    logic [MAX_SERVERS-1:0]     r_ready;
    logic                       r_sending;
    logic [SIW-1:0]             r_pending;
    logic [jqsd_pkg::CFG_W-1:0] r_servers;
    jqsd_pkg::t_out_item        r_out;

    logic [AW-1:0]              n_head;
    logic [AW-1:0]              n_tail;
    logic [FW-1:0]              n_fill;
    logic [MAX_SERVERS-1:0]     n_ready;
    logic                       n_sending;
    logic [SIW-1:0]             n_pending;
    jqsd_pkg::t_out_item        n_out;

    logic [SW-1:0]              rd_data;
    logic                       wr_en;
    logic [NW-1:0]              active;
    logic [MAX_SERVERS-1:0]     act_mask;
    logic [FW-1:0]              fill_mid;
    logic [MAX_SERVERS-1:0]     ready_mid;
    logic                       send_mid;
    logic                       try_match;
    logic                       disp;
    logic [JW-1:0]              djob;
    logic [XW-1:0]              dsrv;
    logic [jqsd_pkg::ERR_W-1:0] err;
    logic [MAX_SERVERS-1:0]     cand;
    logic [MAX_SERVERS-1:0]     low;
    logic [SIW-1:0]             low_idx;

    jqsd_ram #(
        .WIDTH(SW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_item.job_id[SW-1:0]),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    assign active = ({3'b000, r_servers} > MAX_S) ? MAX_S : {3'b000, r_servers};

    always_comb begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
            act_mask[i] = NW'(i) < active;
        end
    end

    always_comb begin
        wr_en     = 1'b0;
        fill_mid  = r_fill;
        ready_mid = r_ready;
        send_mid  = r_sending;
        try_match = 1'b0;
        disp      = 1'b0;
        djob      = '0;
        dsrv      = '0;
        err       = jqsd_pkg::ERR_OK;
        n_head    = r_head;
        n_tail    = r_tail;
        case (r_item.action)
            jqsd_pkg::ACT_ARRIVE: begin
                if (r_fill == FULL) begin
                    err = jqsd_pkg::ERR_FULL;
                end else begin
                    wr_en    = i_cmd.exec;
                    fill_mid = r_fill + 1'b1;
                    n_tail   = (r_tail == LAST) ? '0 : r_tail + 1'b1;
                end
                try_match = !r_sending;
            end
            jqsd_pkg::ACT_PULL: begin
                if ({4'b0000, r_item.server_index} >= active) begin
                    err = jqsd_pkg::ERR_BAD_INDEX;
                end else begin
                    ready_mid = r_ready | (ONE_S << r_item.server_index);
                    try_match = !r_sending;
                end
            end
            jqsd_pkg::ACT_FIRE: begin
                if (!r_sending || r_fill == '0) begin
                    err = jqsd_pkg::ERR_FIRE_IDLE;
                end else begin
                    disp      = 1'b1;
                    djob      = JW'(rd_data);
                    dsrv      = XW'(r_pending);
                    fill_mid  = r_fill - 1'b1;
                    n_head    = (r_head == LAST) ? '0 : r_head + 1'b1;
                    send_mid  = 1'b0;
                    try_match = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // The lowest ready server is isolated by the two's complement trick.
    assign cand = ready_mid & act_mask;
    assign low  = cand & (~cand + ONE_S);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < MAX_SERVERS; i++) begin
            if (low[i]) begin
                low_idx = low_idx | SIW'(i);
            end
        end
    end

    always_comb begin
        n_fill    = fill_mid;
        n_ready   = ready_mid;
        n_sending = send_mid;
        n_pending = r_pending;
        if (try_match && fill_mid != '0 && cand != '0) begin
            n_ready   = ready_mid & ~low;
            n_sending = 1'b1;
            n_pending = low_idx;
        end
        n_out.dispatched      = disp;
        n_out.dispatched_job  = djob;
        n_out.dispatch_server = dsrv;
        n_out.sending         = n_sending;
        n_out.queue_count     = CW'(fill_mid);
        n_out.error_code      = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_ready   <= '0;
            r_sending <= 1'b0;
            r_pending <= '0;
            r_servers <= jqsd_pkg::CFG_SERVERS_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_servers <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_fill    <= n_fill;
                r_ready   <= n_ready;
                r_sending <= n_sending;
                r_pending <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/job_queue_server_dispatcher.sv
// Top level of the job queue server dispatcher.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data (t_in_item)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//   cfg      input      i_cfg_wr_en               i_cfg_wr_data (servers in use)
//
// Each input transfer is taken into the item register while idle and then executed in the execute state.
// The head job is read from the queue memory, with its registered read port, while idle.
// Reset is synchronous and clears pointers, fill, ready bits and phase; the memory is not cleared.
// A result waits in the output register; the next item is taken meanwhile and
// its execution waits until the output register is free.
`timescale 1ns / 1ps

module job_queue_server_dispatcher #(
    parameter int QUEUE_DEPTH = jqsd_pkg::QUEUE_DEPTH,
    parameter int MAX_SERVERS = jqsd_pkg::MAX_SERVERS,
    parameter int JOB_ID_BITS = jqsd_pkg::JOB_ID_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  jqsd_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output jqsd_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_wr_en,
    input  logic [jqsd_pkg::CFG_W-1:0] i_cfg_wr_data
);

    jqsd_pkg::t_ctl_cmd cmd;

    jqsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    jqsd_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_SERVERS(MAX_SERVERS),
        .JOB_ID_BITS(JOB_ID_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (o_out_data)
    );

endmodule

>>> tb/tb_job_queue_server_dispatcher.sv
// Self-checking testbench for the job queue server dispatcher, with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_job_queue_server_dispatcher;

    localparam logic [jqsd_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 110;
    localparam int REPORT_LIMIT = 100;

    class dispatch_scoreboard;
        logic [jqsd_pkg::JOB_W-1:0]       waiting_jobs[$];
        logic [jqsd_pkg::MAX_SERVERS-1:0] ready_mask;
        logic                             busy_sending;
        logic [jqsd_pkg::SIDX_W-1:0]      reserved_server;
        logic [jqsd_pkg::CFG_W-1:0]       servers_cfg;
        jqsd_pkg::t_out_item              due_results[$];
        int                               transfers_noted;
        int                               mismatches;

        function new();
            ready_mask = '0;
            busy_sending = 1'b0;
            reserved_server = '0;
            servers_cfg = jqsd_pkg::CFG_SERVERS_RESET;
            transfers_noted = 0;
            mismatches = 0;
        endfunction

        function int live_servers();
            return (servers_cfg > jqsd_pkg::MAX_SERVERS) ? jqsd_pkg::MAX_SERVERS
                                                         : int'(servers_cfg);
        endfunction

        function void reserve_server();
            int n;
            n = live_servers();
            if (waiting_jobs.size() == 0) return;
            for (int s = 0; s < n; s++) begin
                if (ready_mask[s]) begin
                    ready_mask[s] = 1'b0;
                    reserved_server = jqsd_pkg::SIDX_W'(s);
                    busy_sending = 1'b1;
                    return;
                end
            end
        endfunction

        function void note_transfer(jqsd_pkg::t_in_item it);
            jqsd_pkg::t_out_item res;
            res = '0;
            transfers_noted++;
            case (it.action)
                jqsd_pkg::ACT_ARRIVE: begin
                    if (waiting_jobs.size() >= jqsd_pkg::QUEUE_DEPTH)
                        res.error_code = jqsd_pkg::ERR_FULL;
                    else
                        waiting_jobs.insert(waiting_jobs.size(), it.job_id);
                    if (!busy_sending) reserve_server();
                end
                jqsd_pkg::ACT_PULL: begin
                    if (int'(it.server_index) >= live_servers()) begin
                        res.error_code = jqsd_pkg::ERR_BAD_INDEX;
                    end else begin
                        ready_mask[it.server_index] = 1'b1;
                        if (!busy_sending) reserve_server();
                    end
                end
                jqsd_pkg::ACT_FIRE: begin
                    if (!busy_sending || waiting_jobs.size() == 0) begin
                        res.error_code = jqsd_pkg::ERR_FIRE_IDLE;
                    end else begin
                        res.dispatched = 1'b1;
                        res.dispatched_job = waiting_jobs[0];
                        waiting_jobs.delete(0);
                        res.dispatch_server = reserved_server;
                        busy_sending = 1'b0;
                        reserve_server();
                    end
                end
                default: ;
            endcase
            res.sending = busy_sending;
            res.queue_count = jqsd_pkg::COUNT_W'(waiting_jobs.size());
            due_results.insert(due_results.size(), res);
        endfunction

        function void report_field(string field, logic [jqsd_pkg::JOB_W-1:0] want,
                                   logic [jqsd_pkg::JOB_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(jqsd_pkg::t_out_item got);
            jqsd_pkg::t_out_item want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            if (got.dispatched !== want.dispatched)
                report_field("dispatched", jqsd_pkg::JOB_W'(want.dispatched),
                             jqsd_pkg::JOB_W'(got.dispatched));
            if (got.dispatched_job !== want.dispatched_job)
                report_field("dispatched_job", want.dispatched_job, got.dispatched_job);
            if (got.dispatch_server !== want.dispatch_server)
                report_field("dispatch_server", jqsd_pkg::JOB_W'(want.dispatch_server),
                             jqsd_pkg::JOB_W'(got.dispatch_server));
            if (got.sending !== want.sending)
                report_field("sending", jqsd_pkg::JOB_W'(want.sending),
                             jqsd_pkg::JOB_W'(got.sending));
            if (got.queue_count !== want.queue_count)
                report_field("queue_count", jqsd_pkg::JOB_W'(want.queue_count),
                             jqsd_pkg::JOB_W'(got.queue_count));
            if (got.error_code !== want.error_code)
                report_field("error_code", jqsd_pkg::JOB_W'(want.error_code),
                             jqsd_pkg::JOB_W'(got.error_code));
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    jqsd_pkg::t_in_item         i_in_data;
    logic                       o_out_valid;
    logic                       i_out_stall;
    jqsd_pkg::t_out_item        o_out_data;
    logic                       i_cfg_wr_en;
    logic [jqsd_pkg::CFG_W-1:0] i_cfg_wr_data;

    dispatch_scoreboard dispatch_sb = new();
    int                 items_sent = 0;
    bit                 tx_gaps_on = 1'b1;
    bit                 rx_stalls_on = 1'b1;
    bit                 long_hold_req = 1'b0;

    job_queue_server_dispatcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_job_queue_server_dispatcher failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) dispatch_sb.note_transfer(i_in_data);
            if (o_out_valid && !i_out_stall) dispatch_sb.check_result(o_out_data);
        end
    end

    initial begin : result_side
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic jqsd_pkg::t_in_item make_item(
        logic [jqsd_pkg::ACTION_W-1:0] action,
        logic [jqsd_pkg::JOB_W-1:0]    job_id,
        logic [jqsd_pkg::SIDX_W-1:0]   server_index);
        jqsd_pkg::t_in_item it;
        it.action = action;
        it.job_id = job_id;
        it.server_index = server_index;
        return it;
    endfunction

    function automatic jqsd_pkg::t_in_item random_item(int arrive_w, int pull_w);
        jqsd_pkg::t_in_item it;
        int roll;
        int live;
        live = dispatch_sb.live_servers();
        roll = $urandom_range(0, 99);
        it.job_id = jqsd_pkg::JOB_W'($urandom_range(0, 16'hFFFF));
        it.server_index = jqsd_pkg::SIDX_W'($urandom_range(0, 7));
        if (roll < arrive_w) it.action = jqsd_pkg::ACT_ARRIVE;
        else if (roll < arrive_w + pull_w) it.action = jqsd_pkg::ACT_PULL;
        else if (roll < 97) it.action = jqsd_pkg::ACT_FIRE;
        else it.action = ACT_UNUSED;
        if (it.action == jqsd_pkg::ACT_FIRE && !dispatch_sb.busy_sending
            && $urandom_range(0, 3) != 0)
            it.action = jqsd_pkg::ACT_PULL;
        if (it.action == jqsd_pkg::ACT_PULL && live > 0 && $urandom_range(0, 3) != 0)
            it.server_index = jqsd_pkg::SIDX_W'($urandom_range(0, live - 1));
        return it;
    endfunction

    task automatic send_item(jqsd_pkg::t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        if (i_in_valid) i_in_valid <= 1'b0;
        do @(posedge i_clk);
        while (dispatch_sb.transfers_noted != items_sent || dispatch_sb.due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_servers(logic [jqsd_pkg::CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dispatch_sb.servers_cfg = value;
    endtask

    initial begin : stimulus
        logic [jqsd_pkg::CFG_W-1:0] cfg_plan[6];
        logic [jqsd_pkg::CFG_W-1:0] cfg_value;
        int arrive_w;
        int pull_w;

        cfg_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = jqsd_pkg::CFG_SERVERS_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));
        send_item(make_item(ACT_UNUSED, 16'hFFFF, 3'd7));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'hFFFF, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_ARRIVE, 16'hFFFF, 3'd7));
        send_item(make_item(jqsd_pkg::ACT_ARRIVE, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd7));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'hFFFF, 3'd7));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_ARRIVE, 16'hA5A5, 3'd5));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h5A5A, 3'd3));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));
        wait_for_results();
        write_servers(4'd2);
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd5));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd2));
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd1));
        send_item(make_item(jqsd_pkg::ACT_ARRIVE, 16'h5A5A, 3'd2));
        wait_for_results();
        write_servers(4'd0);
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));
        send_item(make_item(jqsd_pkg::ACT_ARRIVE, 16'h1234, 3'd6));
        wait_for_results();
        write_servers(4'd15);
        send_item(make_item(jqsd_pkg::ACT_PULL, 16'h0000, 3'd7));
        send_item(make_item(jqsd_pkg::ACT_FIRE, 16'h0000, 3'd0));

        for (int ph = 0; ph < 16; ph++) begin
            wait_for_results();
            cfg_value = (ph < 6) ? cfg_plan[ph] : jqsd_pkg::CFG_W'($urandom_range(0, 15));
            write_servers(cfg_value);
            case (ph % 4)
                0: begin arrive_w = 40; pull_w = 30; end
                1: begin arrive_w = 75; pull_w = 10; end
                2: begin arrive_w = 15; pull_w = 40; end
                default: begin arrive_w = 35; pull_w = 25; end
            endcase
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (ph == 5) begin
                tx_gaps_on = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_item(random_item(arrive_w, pull_w));
        end

        wait_for_results();
        write_servers(4'd8);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (150) send_item(random_item(40, 30));
        wait_for_results();
        repeat (10) @(posedge i_clk);

        if (dispatch_sb.mismatches == 0)
            $display("tb_job_queue_server_dispatcher passed");
        else
            $display("tb_job_queue_server_dispatcher failed");
        $finish;
    end

endmodule
